FILE: design/hdrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrp_pkg
// Shared types and constants of the Ethernet / IPv4 / UDP / TCP header parser.
// ----------------------------------------------------------------------------
package hdrp_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int MTU_BYTES       = 1500;
  localparam int FRAME_CAP       = (MTU_BYTES < MAX_FRAME_BYTES) ? MTU_BYTES : MAX_FRAME_BYTES;
  localparam int POS_W           = $clog2(FRAME_CAP + 1);

  localparam int HDR_BYTES = 20;
  localparam int HDR_W     = HDR_BYTES * 8;
  localparam int VAL_W     = 48;
  localparam int PLEN_W    = 12;
  localparam logic [PLEN_W-1:0] PLEN_MAX = '1;

  localparam logic [POS_W-1:0] ETH_LAST = POS_W'(13);
  localparam logic [POS_W-1:0] IP_LAST  = POS_W'(33);
  localparam logic [POS_W-1:0] UDP_LAST = POS_W'(41);
  localparam logic [POS_W-1:0] TCP_LAST = POS_W'(53);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_ETH, PH_IP, PH_UDP, PH_TCP, PH_PAY, PH_NONIP, PH_OTHER
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_NONIP      = 2'd2,
    ST_OTHER      = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    FK_DMAC      = 5'd0,
    FK_SMAC      = 5'd1,
    FK_IPID      = 5'd2,
    FK_FRAG      = 5'd3,
    FK_TTL       = 5'd4,
    FK_IPSUM     = 5'd5,
    FK_PROTO     = 5'd6,
    FK_SIP       = 5'd7,
    FK_DIP       = 5'd8,
    FK_UDP_SPORT = 5'd9,
    FK_UDP_DPORT = 5'd10,
    FK_UDP_LEN   = 5'd11,
    FK_UDP_SUM   = 5'd12,
    FK_TCP_SPORT = 5'd13,
    FK_TCP_DPORT = 5'd14,
    FK_TCP_WIN   = 5'd15,
    FK_TCP_SUM   = 5'd16,
    FK_TCP_SEQ   = 5'd17,
    FK_TCP_ACK   = 5'd18,
    FK_PAYLOAD   = 5'd19,
    FK_STATUS    = 5'd20
  } fkind_t;

  typedef enum logic [2:0] {
    JB_ETH, JB_IP, JB_UDP, JB_TCP, JB_PAY, JB_STAT
  } jkind_t;

  // header byte k sits at hdr[HDR_W-1-8k -: 8]
  typedef struct packed {
    jkind_t              kind;
    logic [HDR_W-1:0]    hdr;
    logic                stat_en;
    status_t             stat_code;
    logic [PLEN_W-1:0]   plen;
  } job_t;

  typedef struct packed {
    fkind_t              kind;
    logic [VAL_W-1:0]    value;
    logic [PLEN_W-1:0]   plen;
    logic                eop;
  } res_t;

endpackage

FILE: design/hdrp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrp_in_if
// Byte channel into the parser: one frame byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface hdrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: design/hdrp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrp_out_if
// Result channel out of the parser: one decoded field or status per request.
// ----------------------------------------------------------------------------
interface hdrp_out_if;
  logic                        valid;
  logic                        ready;
  logic [4:0]                  field_kind;
  logic [hdrp_pkg::VAL_W-1:0]  field_value;
  logic [hdrp_pkg::PLEN_W-1:0] payload_length;
  logic                        end_of_packet;

  modport source (output valid, output field_kind, output field_value,
                  output payload_length, output end_of_packet, input ready);
  modport sink   (input valid, input field_kind, input field_value,
                  input payload_length, input end_of_packet, output ready);
endinterface

FILE: design/hdrp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrp_front
// Takes frame bytes, tracks the parse phase and collects header bytes; each
// byte that causes results becomes one job for the back end.
// ----------------------------------------------------------------------------
module hdrp_front (
  input  logic             clk,
  input  logic             rst_n,
  hdrp_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             q_push,
  output hdrp_pkg::job_t   q_job
);

  hdrp_pkg::phase_t                 phase_r, phase_nxt, phase_adv;
  logic [hdrp_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [hdrp_pkg::PLEN_W-1:0]      cnt_r, cnt_nxt, cnt_adv;
  logic [hdrp_pkg::HDR_W-9:0]       hdr_r;
  logic [hdrp_pkg::HDR_W-1:0]       view;
  logic                             accept;
  logic                             need_job;
  hdrp_pkg::job_t                   job;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign view        = {hdr_r, in_ch.data_byte};

  // next state
  always_comb begin
    phase_adv = phase_r;
    unique case (phase_r)
      hdrp_pkg::PH_ETH: begin
        if (pos_r == hdrp_pkg::ETH_LAST) begin
          phase_adv = (view[15:0] == hdrp_pkg::ETHERTYPE_IPV4) ?
                      hdrp_pkg::PH_IP : hdrp_pkg::PH_NONIP;
        end
      end
      hdrp_pkg::PH_IP: begin
        if (pos_r == hdrp_pkg::IP_LAST) begin
          if (view[87:80] == hdrp_pkg::PROTO_UDP) begin
            phase_adv = hdrp_pkg::PH_UDP;
          end else if (view[87:80] == hdrp_pkg::PROTO_TCP) begin
            phase_adv = hdrp_pkg::PH_TCP;
          end else begin
            phase_adv = hdrp_pkg::PH_OTHER;
          end
        end
      end
      hdrp_pkg::PH_UDP: begin
        if (pos_r == hdrp_pkg::UDP_LAST) phase_adv = hdrp_pkg::PH_PAY;
      end
      hdrp_pkg::PH_TCP: begin
        if (pos_r == hdrp_pkg::TCP_LAST) phase_adv = hdrp_pkg::PH_PAY;
      end
      default: phase_adv = phase_r;
    endcase
    phase_nxt = in_ch.last_byte ? hdrp_pkg::PH_ETH : phase_adv;
  end

  // outputs: job build, position and payload count
  always_comb begin
    job       = '0;
    need_job  = 1'b0;
    cnt_adv   = cnt_r;
    job.kind  = hdrp_pkg::JB_STAT;
    unique case (phase_r)
      hdrp_pkg::PH_ETH: begin
        if (pos_r == hdrp_pkg::ETH_LAST) begin
          need_job = 1'b1;
          job.kind = hdrp_pkg::JB_ETH;
          job.hdr  = {view[111:0], 48'h0};
        end
      end
      hdrp_pkg::PH_IP: begin
        if (pos_r == hdrp_pkg::IP_LAST) begin
          need_job = 1'b1;
          job.kind = hdrp_pkg::JB_IP;
          job.hdr  = view;
        end
      end
      hdrp_pkg::PH_UDP: begin
        if (pos_r == hdrp_pkg::UDP_LAST) begin
          need_job = 1'b1;
          job.kind = hdrp_pkg::JB_UDP;
          job.hdr  = {view[63:0], 96'h0};
        end
      end
      hdrp_pkg::PH_TCP: begin
        if (pos_r == hdrp_pkg::TCP_LAST) begin
          need_job = 1'b1;
          job.kind = hdrp_pkg::JB_TCP;
          job.hdr  = view;
        end
      end
      hdrp_pkg::PH_PAY: begin
        if (pos_r < hdrp_pkg::POS_W'(hdrp_pkg::FRAME_CAP)) begin
          need_job = 1'b1;
          job.kind = hdrp_pkg::JB_PAY;
          job.hdr  = {in_ch.data_byte, {(hdrp_pkg::HDR_W-8){1'b0}}};
          if (cnt_r != hdrp_pkg::PLEN_MAX) cnt_adv = cnt_r + 1'b1;
        end
      end
      default: need_job = 1'b0;
    endcase

    pos_nxt = (pos_r < hdrp_pkg::POS_W'(hdrp_pkg::FRAME_CAP)) ? pos_r + 1'b1 : pos_r;
    cnt_nxt = cnt_adv;

    if (in_ch.last_byte) begin
      need_job    = 1'b1;
      job.stat_en = 1'b1;
      job.plen    = cnt_adv;
      unique case (phase_adv) inside
        hdrp_pkg::PH_PAY:   job.stat_code = hdrp_pkg::ST_OK;
        hdrp_pkg::PH_NONIP: job.stat_code = hdrp_pkg::ST_NONIP;
        hdrp_pkg::PH_ETH, hdrp_pkg::PH_IP, hdrp_pkg::PH_UDP, hdrp_pkg::PH_TCP:
          job.stat_code = hdrp_pkg::ST_INCOMPLETE;
        default:            job.stat_code = hdrp_pkg::ST_OTHER;
      endcase
      pos_nxt = '0;
      cnt_nxt = '0;
    end
  end

  assign q_push = accept && need_job;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hdrp_pkg::PH_ETH;
      pos_r   <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) hdr_r <= view[hdrp_pkg::HDR_W-9:0];
  end

endmodule

FILE: design/hdrp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrp_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module hdrp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hdrp_pkg::job_t   push_job,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output hdrp_pkg::job_t   head_job
);

  hdrp_pkg::job_t                mem_r [hdrp_pkg::QDEPTH];
  logic [hdrp_pkg::QPTR_W-1:0]   wr_r, rd_r;
  logic [hdrp_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign full      = (cnt_r == hdrp_pkg::QCNT_W'(hdrp_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_job  = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

endmodule

FILE: design/hdrp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrp_back
// Expands one job at a time into its field results, one per cycle unless the
// output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module hdrp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  hdrp_pkg::job_t   q_job,
  output logic             q_pop,
  hdrp_out_if.source       out_ch
);

  hdrp_pkg::job_t    cur_r;
  logic              cur_valid_r;
  logic [2:0]        idx_r;
  logic [2:0]        nhdr;
  logic [2:0]        last_idx;
  logic              issue, done;
  logic              out_valid_r;
  hdrp_pkg::res_t    out_res_r;
  hdrp_pkg::res_t    res;
  logic [hdrp_pkg::HDR_W-1:0] h;

  assign h = cur_r.hdr;

  // header results per job kind
  always_comb begin
    unique case (cur_r.kind)
      hdrp_pkg::JB_ETH: nhdr = 3'd2;
      hdrp_pkg::JB_IP:  nhdr = 3'd7;
      hdrp_pkg::JB_UDP: nhdr = 3'd4;
      hdrp_pkg::JB_TCP: nhdr = 3'd6;
      hdrp_pkg::JB_PAY: nhdr = 3'd1;
      default:          nhdr = 3'd0;
    endcase
  end

  assign last_idx = nhdr + {2'b00, cur_r.stat_en} - 3'd1;
  assign issue    = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign done     = issue && (idx_r == last_idx);
  assign q_pop    = q_valid && (!cur_valid_r || done);

  // field select
  always_comb begin
    res = '0;
    if (idx_r >= nhdr) begin
      res.kind  = hdrp_pkg::FK_STATUS;
      res.value = {{(hdrp_pkg::VAL_W-2){1'b0}}, cur_r.stat_code};
      res.plen  = cur_r.plen;
      res.eop   = 1'b1;
    end else begin
      res.kind = hdrp_pkg::FK_PAYLOAD;
      unique case (cur_r.kind)
        hdrp_pkg::JB_ETH: begin
          if (idx_r == 3'd0) begin
            res.kind = hdrp_pkg::FK_DMAC;  res.value = h[159:112];
          end else begin
            res.kind = hdrp_pkg::FK_SMAC;  res.value = h[111:64];
          end
        end
        hdrp_pkg::JB_IP: begin
          case (idx_r)
            3'd0: begin res.kind = hdrp_pkg::FK_IPID;  res.value = 48'(h[127:112]); end
            3'd1: begin res.kind = hdrp_pkg::FK_FRAG;  res.value = 48'(h[111:96]);  end
            3'd2: begin res.kind = hdrp_pkg::FK_TTL;   res.value = 48'(h[95:88]);   end
            3'd3: begin res.kind = hdrp_pkg::FK_IPSUM; res.value = 48'(h[79:64]);   end
            3'd4: begin res.kind = hdrp_pkg::FK_PROTO; res.value = 48'(h[87:80]);   end
            3'd5: begin res.kind = hdrp_pkg::FK_SIP;   res.value = 48'(h[63:32]);   end
            default: begin res.kind = hdrp_pkg::FK_DIP; res.value = 48'(h[31:0]);   end
          endcase
        end
        hdrp_pkg::JB_UDP: begin
          case (idx_r)
            3'd0: begin res.kind = hdrp_pkg::FK_UDP_SPORT; res.value = 48'(h[159:144]); end
            3'd1: begin res.kind = hdrp_pkg::FK_UDP_DPORT; res.value = 48'(h[143:128]); end
            3'd2: begin res.kind = hdrp_pkg::FK_UDP_LEN;   res.value = 48'(h[127:112]); end
            default: begin
              res.kind = hdrp_pkg::FK_UDP_SUM; res.value = 48'(h[111:96]);
            end
          endcase
        end
        hdrp_pkg::JB_TCP: begin
          case (idx_r)
            3'd0: begin res.kind = hdrp_pkg::FK_TCP_SPORT; res.value = 48'(h[159:144]); end
            3'd1: begin res.kind = hdrp_pkg::FK_TCP_DPORT; res.value = 48'(h[143:128]); end
            3'd2: begin res.kind = hdrp_pkg::FK_TCP_WIN;   res.value = 48'(h[47:32]);   end
            3'd3: begin res.kind = hdrp_pkg::FK_TCP_SUM;   res.value = 48'(h[31:16]);   end
            3'd4: begin res.kind = hdrp_pkg::FK_TCP_SEQ;   res.value = 48'(h[127:96]);  end
            default: begin
              res.kind = hdrp_pkg::FK_TCP_ACK; res.value = 48'(h[95:64]);
            end
          endcase
        end
        default: begin
          res.kind  = hdrp_pkg::FK_PAYLOAD;
          res.value = 48'(h[159:152]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (done) begin
        cur_valid_r <= 1'b0;
      end else if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r     <= q_job;
    if (issue) out_res_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.field_kind     = out_res_r.kind;
  assign out_ch.field_value    = out_res_r.value;
  assign out_ch.payload_length = out_res_r.plen;
  assign out_ch.end_of_packet  = out_res_r.eop;

endmodule

FILE: design/eth_ipv4_udp_tcp_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ipv4_udp_tcp_header_parser
// Byte-wide Ethernet / IPv4 / UDP / TCP header parser with payload pass-through.
// Each job passes the queue and the current-job register, then the output stage.
// Throughput: one byte per cycle in and one result per cycle out, both when
// not stalled; header bursts (up to 8 results from one byte) drain through a
// 4-job queue and the field expansion unit at one result per cycle.
// Reset: synchronous active low; clears phase, position, count, queue and valids.
// ----------------------------------------------------------------------------
module eth_ipv4_udp_tcp_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  hdrp_in_if.sink     in_ch,
  hdrp_out_if.source  out_ch
);

  logic             q_push, q_full, q_pop, q_valid;
  hdrp_pkg::job_t   push_job, head_job;

  hdrp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  hdrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_job  (head_job)
  );

  hdrp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: test/eth_ipv4_udp_tcp_header_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ipv4_udp_tcp_header_parser_tb
// Self-checking bench for the byte-wide Ethernet / IPv4 / UDP / TCP header
// parser. A class tracks the parse state of each frame and builds the fields
// the block should emit for every accepted byte. Results are matched in order
// as they leave the block. Stimulus starts with a few short frames. Random
// frames follow, mostly well formed with random content. The rest are cut
// short, non-IP, unknown-protocol or noise frames.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module eth_ipv4_udp_tcp_header_parser_tb;
  import hdrp_pkg::*;

  localparam int IP_BASE     = int'(ETH_LAST) + 1;
  localparam int L4_BASE     = int'(IP_LAST) + 1;
  localparam int ITEM_TARGET = 380;
  localparam int TAIL_CYCLES = 20;
  localparam int LIMIT       = 1000000;
  localparam int PRINT_MAX   = 40;

  typedef enum int {
    FR_UDP, FR_TCP, FR_OTHER, FR_NONIP,
    FR_CUT_ETH, FR_CUT_IP, FR_CUT_UDP, FR_CUT_TCP, FR_NOISE
  } frame_kind_t;

  class frame_field_predictor;
    logic [POS_W-1:0]  pos;
    phase_t            phase;
    logic [7:0]        hdr [HDR_BYTES];
    logic [7:0]        l4_proto;
    logic [PLEN_W-1:0] pay_cnt;
    res_t              pending_fields [$];
    int                mismatches;

    function new();
      restart();
      foreach (hdr[i]) hdr[i] = '0;
      l4_proto   = '0;
      mismatches = 0;
    endfunction

    function void restart();
      pos     = '0;
      phase   = PH_ETH;
      pay_cnt = '0;
    endfunction

    function int pending_count();
      return pending_fields.size();
    endfunction

    function logic [VAL_W-1:0] hdr_field(int off, int len);
      logic [VAL_W-1:0] v;
      v = '0;
      for (int i = 0; i < len; i++) v = {v[VAL_W-9:0], hdr[off+i]};
      return v;
    endfunction

    function void push_field(fkind_t k, logic [VAL_W-1:0] v,
                             logic [PLEN_W-1:0] pl = '0, logic e = 1'b0);
      res_t r;
      r.kind  = k;
      r.value = v;
      r.plen  = pl;
      r.eop   = e;
      pending_fields.push_back(r);
    endfunction

    function void take_byte(logic [7:0] d, logic l);
      status_t code;
      case (phase)
        PH_ETH: begin
          hdr[pos] = d;
          if (pos == ETH_LAST) begin
            push_field(FK_DMAC, hdr_field(0, 6));
            push_field(FK_SMAC, hdr_field(6, 6));
            phase = ({hdr[12], hdr[13]} == ETHERTYPE_IPV4) ? PH_IP : PH_NONIP;
          end
        end
        PH_IP: begin
          hdr[int'(pos) - IP_BASE] = d;
          if (pos == IP_LAST) begin
            push_field(FK_IPID, hdr_field(4, 2));
            push_field(FK_FRAG, hdr_field(6, 2));
            push_field(FK_TTL, hdr_field(8, 1));
            push_field(FK_IPSUM, hdr_field(10, 2));
            push_field(FK_PROTO, hdr_field(9, 1));
            push_field(FK_SIP, hdr_field(12, 4));
            push_field(FK_DIP, hdr_field(16, 4));
            l4_proto = hdr[9];
            if (l4_proto == PROTO_UDP) phase = PH_UDP;
            else if (l4_proto == PROTO_TCP) phase = PH_TCP;
            else phase = PH_OTHER;
          end
        end
        PH_UDP: begin
          hdr[int'(pos) - L4_BASE] = d;
          if (pos == UDP_LAST) begin
            push_field(FK_UDP_SPORT, hdr_field(0, 2));
            push_field(FK_UDP_DPORT, hdr_field(2, 2));
            push_field(FK_UDP_LEN, hdr_field(4, 2));
            push_field(FK_UDP_SUM, hdr_field(6, 2));
            phase = PH_PAY;
          end
        end
        PH_TCP: begin
          hdr[int'(pos) - L4_BASE] = d;
          if (pos == TCP_LAST) begin
            push_field(FK_TCP_SPORT, hdr_field(0, 2));
            push_field(FK_TCP_DPORT, hdr_field(2, 2));
            push_field(FK_TCP_WIN, hdr_field(14, 2));
            push_field(FK_TCP_SUM, hdr_field(16, 2));
            push_field(FK_TCP_SEQ, hdr_field(4, 4));
            push_field(FK_TCP_ACK, hdr_field(8, 4));
            phase = PH_PAY;
          end
        end
        PH_PAY: begin
          if (pos < FRAME_CAP) begin
            push_field(FK_PAYLOAD, VAL_W'(d));
            if (pay_cnt < PLEN_MAX) pay_cnt++;
          end
        end
        default: begin
        end
      endcase

      if (pos < FRAME_CAP) pos++;

      if (l) begin
        case (phase)
          PH_PAY:   code = ST_OK;
          PH_NONIP: code = ST_NONIP;
          PH_OTHER: code = ST_OTHER;
          default:  code = ST_INCOMPLETE;
        endcase
        push_field(FK_STATUS, VAL_W'(code), pay_cnt, 1'b1);
        restart();
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_MAX) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task match_field(logic [4:0] k, logic [VAL_W-1:0] v, logic [PLEN_W-1:0] pl, logic e);
      res_t want;
      if (pending_fields.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %h", k, v));
        return;
      end
      want = pending_fields.pop_front();
      if (k !== want.kind)
        report_mismatch($sformatf("field_kind got %0d want %0d", k, want.kind));
      if (v !== want.value)
        report_mismatch($sformatf("field_value kind %0d got %h want %h", want.kind, v,
                                  want.value));
      if (pl !== want.plen)
        report_mismatch($sformatf("payload_length kind %0d got %0d want %0d", want.kind,
                                  pl, want.plen));
      if (e !== want.eop)
        report_mismatch($sformatf("end_of_packet kind %0d got %b want %b", want.kind, e,
                                  want.eop));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hdrp_in_if  in_ch ();
  hdrp_out_if out_ch ();

  eth_ipv4_udp_tcp_header_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_field_predictor fields = new();

  logic [7:0] frame_q [$];
  bit         drv_on;
  int         drv_calm;
  int         cycles = 0;

  always #5 clk = ~clk;

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // accepted requests
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      fields.take_byte(in_ch.data_byte, in_ch.last_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      fields.match_field(out_ch.field_kind, out_ch.field_value, out_ch.payload_length,
                         out_ch.end_of_packet);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 4);
    if (r < 90) return $urandom_range(5, 16);
    return $urandom_range(17, 40);
  endfunction

  // result sink with random stalls and calm stretches
  initial begin : result_sink
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm > 0) begin
        calm--;
        out_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 5) calm = $urandom_range(20, 80);
        else if ($urandom_range(0, 99) < 35) stall = gap_len();
        out_ch.ready <= (stall == 0);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    if (drv_calm > 0) begin
      drv_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 4) drv_calm = $urandom_range(20, 60);
      gap = gap_len();
    end
    if (gap > 0) begin
      if (drv_on) in_ch.valid <= 1'b0;
      drv_on = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= l;
    drv_on = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic drain_results();
    if (drv_on) in_ch.valid <= 1'b0;
    drv_on = 1'b0;
    @(posedge clk);
    while (fields.pending_count() != 0) @(posedge clk);
  endtask

  // fills frame_q, returns its length in bytes
  function automatic int build_frame(frame_kind_t k, int pay);
    int         len;
    logic [7:0] p;
    frame_q.delete();
    for (int i = 0; i < L4_BASE + 20; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    if (k != FR_NONIP && k != FR_NOISE) begin
      frame_q[12] = ETHERTYPE_IPV4[15:8];
      frame_q[13] = ETHERTYPE_IPV4[7:0];
    end else if (k == FR_NONIP && {frame_q[12], frame_q[13]} == ETHERTYPE_IPV4) begin
      frame_q[13] = ~frame_q[13];
    end
    case (k)
      FR_UDP, FR_CUT_UDP: p = PROTO_UDP;
      FR_TCP, FR_CUT_TCP: p = PROTO_TCP;
      FR_OTHER: begin
        p = 8'($urandom_range(0, 255));
        if (p == PROTO_UDP || p == PROTO_TCP) p = 8'hFF;
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       p = PROTO_UDP;
          1:       p = PROTO_TCP;
          default: p = 8'($urandom_range(0, 255));
        endcase
      end
    endcase
    if (k != FR_NOISE && k != FR_NONIP) frame_q[IP_BASE + 9] = p;
    case (k)
      FR_UDP:     len = int'(UDP_LAST) + 1 + pay;
      FR_TCP:     len = int'(TCP_LAST) + 1 + pay;
      FR_OTHER:   len = L4_BASE + pay;
      FR_NONIP:   len = IP_BASE + pay;
      FR_CUT_ETH: len = $urandom_range(0, 1) ? IP_BASE : $urandom_range(1, IP_BASE);
      FR_CUT_IP:  len = $urandom_range(0, 1) ? L4_BASE : $urandom_range(IP_BASE + 1, L4_BASE);
      FR_CUT_UDP: len = $urandom_range(0, 1) ? int'(UDP_LAST) + 1 :
                        $urandom_range(L4_BASE + 1, int'(UDP_LAST) + 1);
      FR_CUT_TCP: len = $urandom_range(0, 1) ? int'(TCP_LAST) + 1 :
                        $urandom_range(L4_BASE + 1, int'(TCP_LAST) + 1);
      default:    len = $urandom_range(1, 30);
    endcase
    while (frame_q.size() > len) void'(frame_q.pop_back());
    while (frame_q.size() < len) frame_q.push_back(8'($urandom_range(0, 255)));
    return len;
  endfunction

  initial begin : stimulus
    int          counted;
    int          frame_no;
    bit          paused;
    frame_kind_t k;
    int          r;
    counted  = 0;
    frame_no = 0;
    paused   = 1'b0;
    drv_on   = 1'b0;
    drv_calm = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte frames and an all-ones non-IP header
    frame_q = '{8'h00};
    send_frame();
    counted += frame_q.size();
    frame_q = '{8'hFF};
    send_frame();
    counted += frame_q.size();
    frame_q.delete();
    repeat (IP_BASE) frame_q.push_back(8'hFF);
    send_frame();
    counted += frame_q.size();

    while (counted < ITEM_TARGET) begin
      if (frame_no < int'(FR_NOISE)) begin
        k = frame_kind_t'(frame_no);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) k = FR_UDP;
        else if (r < 60) k = FR_TCP;
        else if (r < 68) k = FR_OTHER;
        else if (r < 75) k = FR_NONIP;
        else if (r < 91) k = frame_kind_t'($urandom_range(int'(FR_CUT_ETH), int'(FR_CUT_TCP)));
        else k = FR_NOISE;
      end
      counted += build_frame(k, payload_len());
      send_frame();
      frame_no++;
      if (!paused && counted > ITEM_TARGET / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fields.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
